FILE: sv/rlbc_pkg.sv
package rlbc_pkg;

   localparam logic [15:0] DUTY_MAX     = 16'd1000;
   localparam logic [7:0]  WHITE_COLOR  = 8'd7;
   localparam logic [15:0] PERIOD_RESET = 16'd1000;

   // floor(2^32 / DUTY_MAX); quotient estimate is low by at most one
   localparam logic [32:0] DUTY_RECIP = 33'((65'd1 << 32) / 65'(DUTY_MAX));

   typedef enum logic [2:0] {
      OP_SET        = 3'd0,
      OP_BRIGHTNESS = 3'd1,
      OP_ON         = 3'd2,
      OP_OFF        = 3'd3,
      OP_TICK       = 3'd4
   } op_type;

   localparam logic [1:0] CSR_PERIOD_A  = 2'd0;
   localparam logic [1:0] CSR_PERIOD_B  = 2'd1;
   localparam logic [1:0] CSR_PERIOD_C  = 2'd2;
   localparam logic [1:0] CSR_GPIO_MASK = 2'd3;

endpackage

FILE: sv/rgb_led_blink_controller.sv
// Three-channel LED controller. Each request item (set, brightness, on, off or
// a one-millisecond tick) updates the color, duty and blink state at the edge it is
// accepted and yields one response item with the three channel levels now driven
// and a reject flag. A new item can be taken every cycle unless rsp_stall backs up
// the pipeline. Levels come from the pipeline that scales each channel period by
// the duty and divides by DUTY_MAX (period product, reciprocal product in two
// halves, quotient assembly, back-multiply, one-step correction). Channel a follows
// color bit 2, b bit 1, c bit 0. The user must write period and GPIO mask registers
// through the csr port only while no item is in flight; this is not enforced.
module rgb_led_blink_controller (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_color,
   input  logic [15:0] req_duty,
   input  logic [15:0] req_blink_period_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_level_a,
   output logic [15:0] rsp_level_b,
   output logic [15:0] rsp_level_c,
   output logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data
);

   typedef struct packed {
      logic [2:0] pwm;
      logic [2:0] fixed;
      logic       status;
   } ctl_type;

   // configuration, index 2 = channel a, 1 = b, 0 = c
   logic [2:0][15:0] period_ff;
   logic [2:0]       gpio_mask_ff;

   // blink state
   logic [7:0]  active_color_ff, active_color_in;
   logic [15:0] active_duty_ff, active_duty_in;
   logic [15:0] blink_period_ff, blink_period_in;
   logic        phase_on_ff, phase_on_in;
   logic        blinking_ff, blinking_in;
   logic [15:0] ms_count_ff, ms_count_in;
   logic [15:0] applied_duty_ff, applied_duty_in;
   logic        status_in;

   // pipeline
   logic [4:0] vld_ff;
   logic       rsp_valid_ff;
   logic [5:0] rdy;
   logic       accept;

   ctl_type          ctl_ff [5];
   ctl_type          ctl_in;
   logic [15:0]      duty1_ff;
   logic [2:0][31:0] prod2_ff, prod3_ff, prod4_ff, prod5_ff;
   logic [2:0][48:0] ph_ff, pl_ff;
   logic [2:0][65:0] sum;
   logic [2:0][15:0] q0_ff, q05_ff;
   logic [2:0][31:0] qd_ff;
   logic [2:0][31:0] rem;
   logic [2:0][15:0] level_ff, level_in;
   logic             status_ff;

   // command decode and state update
   logic [7:0]  set_color;
   logic [15:0] set_duty;
   logic [15:0] set_period;
   logic        do_set;
   logic [15:0] ms_next;

   always_comb begin
      active_color_in = active_color_ff;
      active_duty_in  = active_duty_ff;
      blink_period_in = blink_period_ff;
      phase_on_in     = phase_on_ff;
      blinking_in     = blinking_ff;
      ms_count_in     = ms_count_ff;
      applied_duty_in = applied_duty_ff;
      status_in       = 1'b0;
      do_set          = 1'b0;
      set_color       = (active_color_ff != 8'd0) ? active_color_ff : rlbc_pkg::WHITE_COLOR;
      set_duty        = req_duty;
      set_period      = blink_period_ff;
      ms_next         = ms_count_ff + 16'd1;
      case (req_operation)
         rlbc_pkg::OP_SET: begin
            do_set     = 1'b1;
            set_color  = req_color;
            set_period = req_blink_period_ms;
         end
         rlbc_pkg::OP_BRIGHTNESS: begin
            do_set = 1'b1;
         end
         rlbc_pkg::OP_ON: begin
            do_set   = 1'b1;
            set_duty = (active_duty_ff != 16'd0) ? active_duty_ff : rlbc_pkg::DUTY_MAX;
         end
         rlbc_pkg::OP_OFF: begin
            blinking_in     = 1'b0;
            ms_count_in     = 16'd0;
            applied_duty_in = 16'd0;
         end
         rlbc_pkg::OP_TICK: begin
            if (blinking_ff) begin
               if (ms_next >= blink_period_ff) begin
                  ms_count_in     = 16'd0;
                  phase_on_in     = ~phase_on_ff;
                  applied_duty_in = phase_on_ff ? 16'd0 : active_duty_ff;
               end else begin
                  ms_count_in = ms_next;
               end
            end
         end
         default: begin
         end
      endcase
      if (do_set) begin
         if (set_duty > rlbc_pkg::DUTY_MAX) begin
            status_in = 1'b1;
         end else begin
            active_color_in = set_color;
            active_duty_in  = set_duty;
            blink_period_in = set_period;
            phase_on_in     = 1'b1;
            ms_count_in     = 16'd0;
            applied_duty_in = set_duty;
            blinking_in     = (set_period != 16'd0) && (set_duty != 16'd0);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ctl_in.pwm[i]   = active_color_in[i] & ~gpio_mask_ff[i];
         ctl_in.fixed[i] = active_color_in[i] & gpio_mask_ff[i] & (applied_duty_in != 16'd0);
      end
      ctl_in.status = status_in;
   end

   // stage ready chain
   always_comb begin
      rdy[5] = ~rsp_valid_ff | ~rsp_stall;
      for (int k = 4; k >= 0; k--) begin
         rdy[k] = ~vld_ff[k] | rdy[k+1];
      end
   end

   assign accept    = req_valid & rdy[0];
   assign req_stall = ~rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= {3{rlbc_pkg::PERIOD_RESET}};
         gpio_mask_ff    <= 3'd0;
         active_color_ff <= 8'd0;
         active_duty_ff  <= 16'd0;
         blink_period_ff <= 16'd0;
         phase_on_ff     <= 1'b0;
         blinking_ff     <= 1'b0;
         ms_count_ff     <= 16'd0;
         applied_duty_ff <= 16'd0;
         vld_ff          <= 5'd0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rlbc_pkg::CSR_PERIOD_A:  period_ff[2]  <= csr_write_data;
               rlbc_pkg::CSR_PERIOD_B:  period_ff[1]  <= csr_write_data;
               rlbc_pkg::CSR_PERIOD_C:  period_ff[0]  <= csr_write_data;
               rlbc_pkg::CSR_GPIO_MASK: gpio_mask_ff  <= csr_write_data[2:0];
               default: begin
               end
            endcase
         end
         if (accept) begin
            active_color_ff <= active_color_in;
            active_duty_ff  <= active_duty_in;
            blink_period_ff <= blink_period_in;
            phase_on_ff     <= phase_on_in;
            blinking_ff     <= blinking_in;
            ms_count_ff     <= ms_count_in;
            applied_duty_ff <= applied_duty_in;
         end
         if (rdy[0]) begin
            vld_ff[0] <= accept;
         end
         for (int k = 1; k < 5; k++) begin
            if (rdy[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
         if (rdy[5]) begin
            rsp_valid_ff <= vld_ff[4];
         end
      end
   end

   // level datapath
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         sum[i] = 66'({ph_ff[i], 16'd0}) + 66'(pl_ff[i]);
         rem[i] = prod5_ff[i] - qd_ff[i];
         if (ctl_ff[4].pwm[i]) begin
            level_in[i] = (rem[i] >= 32'(rlbc_pkg::DUTY_MAX)) ? q05_ff[i] + 16'd1 : q05_ff[i];
         end else begin
            level_in[i] = {15'd0, ctl_ff[4].fixed[i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         duty1_ff  <= applied_duty_in;
         ctl_ff[0] <= ctl_in;
      end
      for (int k = 1; k < 5; k++) begin
         if (rdy[k]) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (rdy[1]) begin
            prod2_ff[i] <= 32'(period_ff[i]) * 32'(duty1_ff);
         end
         if (rdy[2]) begin
            ph_ff[i]    <= 49'(prod2_ff[i][31:16]) * 49'(rlbc_pkg::DUTY_RECIP);
            pl_ff[i]    <= 49'(prod2_ff[i][15:0]) * 49'(rlbc_pkg::DUTY_RECIP);
            prod3_ff[i] <= prod2_ff[i];
         end
         if (rdy[3]) begin
            q0_ff[i]    <= sum[i][47:32];
            prod4_ff[i] <= prod3_ff[i];
         end
         if (rdy[4]) begin
            qd_ff[i]    <= 32'(q0_ff[i]) * 32'(rlbc_pkg::DUTY_MAX);
            q05_ff[i]   <= q0_ff[i];
            prod5_ff[i] <= prod4_ff[i];
         end
         if (rdy[5]) begin
            level_ff[i] <= level_in[i];
         end
      end
      if (rdy[5]) begin
         status_ff <= ctl_ff[4].status;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_level_a = level_ff[2];
   assign rsp_level_b = level_ff[1];
   assign rsp_level_c = level_ff[0];
   assign rsp_status  = status_ff;

`ifndef SYNTHESIS
   a_applied_in_range: assert property (@(posedge clock) disable iff (reset)
      applied_duty_ff <= rlbc_pkg::DUTY_MAX)
      else $error("applied duty above maximum");

   a_blink_needs_period: assert property (@(posedge clock) disable iff (reset)
      blinking_ff |-> (blink_period_ff != 16'd0) && (active_duty_ff != 16'd0))
      else $error("blinking with zero period or duty");

   a_ms_below_period: assert property (@(posedge clock) disable iff (reset)
      blinking_ff |-> ms_count_ff < blink_period_ff)
      else $error("ms counter past blink period");

   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation == rlbc_pkg::OP_SET) && (req_duty > rlbc_pkg::DUTY_MAX)
      |=> $stable(active_color_ff) && $stable(active_duty_ff) && $stable(applied_duty_ff))
      else $error("rejected set changed state");
`endif

endmodule

FILE: tb/sv/rgb_led_blink_checker.sv
`timescale 1ns / 100ps

module rgb_led_blink_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [2:0]  req_operation,
   input  logic [7:0]  req_color,
   input  logic [15:0] req_duty,
   input  logic [15:0] req_blink_period_ms,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [15:0] rsp_level_a,
   input  logic [15:0] rsp_level_b,
   input  logic [15:0] rsp_level_c,
   input  logic        rsp_status,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_write_data,
   output int          mismatch_count,
   output int          levels_pending
);

   typedef struct packed {
      logic [15:0] level_a;
      logic [15:0] level_b;
      logic [15:0] level_c;
      logic        status;
   } led_levels_type;

   led_levels_type expected_levels[$];

   // channel periods, index 0 is channel a
   logic [15:0] period_q [3];
   logic [2:0]  gpio_mask_q;

   logic [7:0]  color_q;
   logic [15:0] duty_q;
   logic [15:0] blink_half_q;
   logic [15:0] ms_count_q;
   logic [15:0] drive_duty_q;
   logic        phase_on_q;
   logic        blinking_q;

   initial mismatch_count = 0;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      $display("%0t: %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   function automatic logic [15:0] channel_level(input int bit_idx,
                                                 input logic [15:0] period);
      logic [31:0] scaled;
      if (!color_q[bit_idx]) return 16'd0;
      if (gpio_mask_q[bit_idx]) return {15'd0, drive_duty_q != 16'd0};
      scaled = (32'(period) * 32'(drive_duty_q)) / 32'(rlbc_pkg::DUTY_MAX);
      return scaled[15:0];
   endfunction

   function automatic logic store_setting(input logic [7:0] color,
                                          input logic [15:0] duty,
                                          input logic [15:0] half);
      if (duty > rlbc_pkg::DUTY_MAX) return 1'b1;
      color_q      = color;
      duty_q       = duty;
      blink_half_q = half;
      phase_on_q   = 1'b1;
      ms_count_q   = 16'd0;
      drive_duty_q = duty;
      blinking_q   = (half != 16'd0) && (duty != 16'd0);
      return 1'b0;
   endfunction

   function automatic led_levels_type run_command(input logic [2:0] op,
                                                  input logic [7:0] color,
                                                  input logic [15:0] duty,
                                                  input logic [15:0] half);
      led_levels_type result;
      logic           status;
      logic [7:0]     use_color;
      logic [15:0]    on_duty;
      status    = 1'b0;
      use_color = (color_q != 8'd0) ? color_q : rlbc_pkg::WHITE_COLOR;
      on_duty   = (duty_q != 16'd0) ? duty_q : rlbc_pkg::DUTY_MAX;
      case (op)
         rlbc_pkg::OP_SET:        status = store_setting(color, duty, half);
         rlbc_pkg::OP_BRIGHTNESS: status = store_setting(use_color, duty, blink_half_q);
         rlbc_pkg::OP_ON:         status = store_setting(use_color, on_duty, blink_half_q);
         rlbc_pkg::OP_OFF: begin
            blinking_q   = 1'b0;
            ms_count_q   = 16'd0;
            drive_duty_q = 16'd0;
         end
         rlbc_pkg::OP_TICK: begin
            if (blinking_q) begin
               ms_count_q = ms_count_q + 16'd1;
               if (ms_count_q >= blink_half_q) begin
                  ms_count_q   = 16'd0;
                  phase_on_q   = !phase_on_q;
                  drive_duty_q = phase_on_q ? duty_q : 16'd0;
               end
            end
         end
         default: ;
      endcase
      result.level_a = channel_level(2, period_q[0]);
      result.level_b = channel_level(1, period_q[1]);
      result.level_c = channel_level(0, period_q[2]);
      result.status  = status;
      return result;
   endfunction

   always @(posedge clock) begin
      led_levels_type want;
      if (reset) begin
         period_q     = '{rlbc_pkg::PERIOD_RESET, rlbc_pkg::PERIOD_RESET,
                          rlbc_pkg::PERIOD_RESET};
         gpio_mask_q  = 3'd0;
         color_q      = 8'd0;
         duty_q       = 16'd0;
         blink_half_q = 16'd0;
         ms_count_q   = 16'd0;
         drive_duty_q = 16'd0;
         phase_on_q   = 1'b0;
         blinking_q   = 1'b0;
         expected_levels.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               rlbc_pkg::CSR_PERIOD_A:  period_q[0] = csr_write_data;
               rlbc_pkg::CSR_PERIOD_B:  period_q[1] = csr_write_data;
               rlbc_pkg::CSR_PERIOD_C:  period_q[2] = csr_write_data;
               rlbc_pkg::CSR_GPIO_MASK: gpio_mask_q = csr_write_data[2:0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            expected_levels.push_back(run_command(req_operation, req_color, req_duty,
                                                  req_blink_period_ms));
         if (rsp_valid && !rsp_stall) begin
            if (expected_levels.size() == 0) begin
               report_mismatch("unexpected item", rsp_level_a, 16'd0);
            end else begin
               want = expected_levels.pop_front();
               if (rsp_level_a !== want.level_a)
                  report_mismatch("level_a", rsp_level_a, want.level_a);
               if (rsp_level_b !== want.level_b)
                  report_mismatch("level_b", rsp_level_b, want.level_b);
               if (rsp_level_c !== want.level_c)
                  report_mismatch("level_c", rsp_level_c, want.level_c);
               if (rsp_status !== want.status)
                  report_mismatch("status", {15'd0, rsp_status}, {15'd0, want.status});
            end
         end
      end
      levels_pending = expected_levels.size();
   end

endmodule

FILE: tb/sv/rgb_led_blink_controller_tb.sv
`timescale 1ns / 100ps

module rgb_led_blink_controller_tb;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_operation;
   logic [7:0]  req_color;
   logic [15:0] req_duty;
   logic [15:0] req_blink_period_ms;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [15:0] rsp_level_a;
   logic [15:0] rsp_level_b;
   logic [15:0] rsp_level_c;
   logic        rsp_status;
   logic        csr_write_enable;
   logic [1:0]  csr_index;
   logic [15:0] csr_write_data;

   int mismatch_count;
   int levels_pending;
   int idle_pct  = 0;
   int stall_pct = 0;
   int hold_len  = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rgb_led_blink_controller dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_color           (req_color),
      .req_duty            (req_duty),
      .req_blink_period_ms (req_blink_period_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_a         (rsp_level_a),
      .rsp_level_b         (rsp_level_b),
      .rsp_level_c         (rsp_level_c),
      .rsp_status          (rsp_status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   rgb_led_blink_checker leds_check (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_operation       (req_operation),
      .req_color           (req_color),
      .req_duty            (req_duty),
      .req_blink_period_ms (req_blink_period_ms),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_level_a         (rsp_level_a),
      .rsp_level_b         (rsp_level_b),
      .rsp_level_c         (rsp_level_c),
      .rsp_status          (rsp_status),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data),
      .mismatch_count      (mismatch_count),
      .levels_pending      (levels_pending)
   );

   // receiver: random stall, or a long hold-off counted here
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_item(input logic [2:0] op, input logic [7:0] color,
                            input logic [15:0] duty, input logic [15:0] half);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_operation       <= op;
      req_color           <= color;
      req_duty            <= duty;
      req_blink_period_ms <= half;
      req_valid           <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_item();
      int          pick;
      logic [2:0]  op;
      logic [15:0] duty;
      logic [15:0] half;
      pick = $urandom_range(99);
      if (pick < 40)      op = rlbc_pkg::OP_TICK;
      else if (pick < 62) op = rlbc_pkg::OP_SET;
      else if (pick < 74) op = rlbc_pkg::OP_BRIGHTNESS;
      else if (pick < 84) op = rlbc_pkg::OP_ON;
      else if (pick < 95) op = rlbc_pkg::OP_OFF;
      else                op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      pick = $urandom_range(99);
      if (pick < 10)      duty = 16'd0;
      else if (pick < 20) duty = rlbc_pkg::DUTY_MAX;
      else if (pick < 32) duty = 16'($urandom_range(65535));
      else                duty = 16'($urandom_range(rlbc_pkg::DUTY_MAX));
      pick = $urandom_range(99);
      if (pick < 45)      half = 16'($urandom_range(1, 4));
      else if (pick < 60) half = 16'd0;
      else if (pick < 75) half = 16'($urandom_range(5, 40));
      else if (pick < 90) half = 16'($urandom);
      else                half = 16'hFFFF;
      send_item(op, 8'($urandom), duty, half);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_channels(input logic [15:0] pa, input logic [15:0] pb,
                                   input logic [15:0] pc, input logic [2:0] mask);
      write_csr(rlbc_pkg::CSR_PERIOD_A, pa);
      write_csr(rlbc_pkg::CSR_PERIOD_B, pb);
      write_csr(rlbc_pkg::CSR_PERIOD_C, pc);
      write_csr(rlbc_pkg::CSR_GPIO_MASK, {13'd0, mask});
      @(posedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (levels_pending != 0) @(negedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic run_directed();
      send_item(rlbc_pkg::OP_TICK, 8'd0, 16'd0, 16'd0);
      send_item(OP_SPARE_FIRST, 8'hFF, 16'hFFFF, 16'hFFFF);
      // nothing stored yet: white at full duty
      send_item(rlbc_pkg::OP_ON, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_OFF, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'hFF, rlbc_pkg::DUTY_MAX, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'h07, 16'(rlbc_pkg::DUTY_MAX + 16'd1), 16'd5);
      send_item(rlbc_pkg::OP_SET, 8'h07, 16'hFFFF, 16'd5);
      send_item(OP_SPARE_LAST, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'h00, 16'd500, 16'd3);
      send_item(rlbc_pkg::OP_BRIGHTNESS, 8'hFF, 16'd250, 16'd0);
      send_item(rlbc_pkg::OP_BRIGHTNESS, 8'd0, 16'd1001, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'h05, 16'd1, 16'd1);
      repeat (3) send_item(rlbc_pkg::OP_TICK, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'h02, 16'd0, 16'd5);
      send_item(rlbc_pkg::OP_TICK, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_ON, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_SET, 8'hAA, 16'd700, 16'hFFFF);
      send_item(rlbc_pkg::OP_SET, 8'h03, 16'd300, 16'd2);
      repeat (4) send_item(rlbc_pkg::OP_TICK, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_OFF, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_TICK, 8'd0, 16'd0, 16'd0);
      send_item(rlbc_pkg::OP_ON, 8'd0, 16'd0, 16'd0);
   endtask

   initial begin
      int phase_idx;
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_operation       = 3'd0;
      req_color           = 8'd0;
      req_duty            = 16'd0;
      req_blink_period_ms = 16'd0;
      csr_write_enable    = 1'b0;
      csr_index           = 2'd0;
      csr_write_data      = 16'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase_idx = 0; phase_idx < 5; phase_idx++) begin
         case (phase_idx)
            1: program_channels(16'hFFFF, 16'd1, 16'd0, 3'b000);
            2: program_channels(16'd7, 16'hFFFF, 16'd1, 3'b111);
            3: program_channels(16'($urandom), 16'($urandom), 16'($urandom),
                                3'($urandom));
            4: program_channels(16'd1000, 16'd333, 16'hFFFF, 3'b101);
            default: ;
         endcase
         case (phase_idx)
            1: begin idle_pct = 49; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 49; end
            3: begin idle_pct = 14; stall_pct = 14; end
            default: begin idle_pct = 0; stall_pct = 0; end
         endcase
         if (phase_idx == 4) hold_len = 300;
         if (phase_idx == 0) run_directed();
         repeat (110) send_random_item();
         drain_results();
      end

      if (mismatch_count == 0 && levels_pending == 0) begin
         $display("rgb_led_blink_controller: match");
      end else begin
         $display("rgb_led_blink_controller: mismatch");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("rgb_led_blink_controller: mismatch");
      $finish;
   end

endmodule

FILE: files.f
sv/rlbc_pkg.sv
sv/rgb_led_blink_controller.sv
tb/sv/rgb_led_blink_checker.sv
tb/sv/rgb_led_blink_controller_tb.sv
